@@ rtl/extended_gcd_nonneg_solution_assert.svh @@
// Assertion macros for the extended gcd block.
// Used by the top level only; depends on nothing else.
`ifndef EXTENDED_GCD_NONNEG_SOLUTION_ASSERT_SVH
`define EXTENDED_GCD_NONNEG_SOLUTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EGCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("egcd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("egcd: next-cycle check failed");

`endif

@@ rtl/egcd_pkg.sv @@
// Shared widths and types for the extended gcd block.
// No dependencies; used by every module of the block.
package egcd_pkg;

	localparam int VALUE_BITS = 31;
	// Bezout coefficients stay within +/- 2**VALUE_BITS.
	localparam int COEF_W     = VALUE_BITS + 1;
	localparam int CNT_W      = $clog2(VALUE_BITS);

	typedef logic [VALUE_BITS-1:0]    value_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	// Status and results handed back by the shared division unit.
	typedef struct packed {
		logic   done;
		value_t rem;
		coef_t  prod_s;
		coef_t  prod_t;
	} div_res_t;

endpackage

@@ rtl/extended_gcd_nonneg_solution.sv @@
// Extended gcd block: top level with the Euclid sequencer and output register.
// Depends on egcd_pkg, egcd_div_unit, egcd_reduce and the assertion header.
//
// Usage:
//   Request channel (req_valid/req_ready) carries a_value and b_value.
//   Result channel (res_valid/res_ready) carries divisor = gcd(a,b) and the
//   least nonnegative coef_x, coef_y with b*y - a*x = divisor.
//   One request is in flight at a time; req_ready is high only when idle.
//   Each Euclid step runs one pass of the shared bit-serial divider, which
//   also accumulates q*s1 and q*t1. With 31-bit operands there are at most
//   45 steps (one of them the swap step when a < b).
//   A zero operand skips the loop.
//   The finished result sits in an output register; a new request is taken
//   while it waits. If the receiver stalls and the next result is ready,
//   the sequencer holds in its final state until the register frees up.
//   Reset (arst_n low, asynchronous) returns to idle and drops res_valid.
//   Zero b gives (a, 0, 0); zero a with nonzero b gives (b, 0, 1).
`include "extended_gcd_nonneg_solution_assert.svh"

module extended_gcd_nonneg_solution (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  egcd_pkg::value_t a_value,
	input  egcd_pkg::value_t b_value,
	output logic             res_valid,
	input  logic             res_ready,
	output egcd_pkg::value_t divisor,
	output egcd_pkg::value_t coef_x,
	output egcd_pkg::value_t coef_y
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_FIN
	} state_t;

	state_t state_q;

	// Euclid remainders and Bezout coefficient pairs
	egcd_pkg::value_t r0_q;
	egcd_pkg::value_t r1_q;
	egcd_pkg::coef_t  s0_q;
	egcd_pkg::coef_t  s1_q;
	egcd_pkg::coef_t  t0_q;
	egcd_pkg::coef_t  t1_q;
	logic             zero_a_q;
	logic             zero_b_q;

	logic             res_valid_q;
	egcd_pkg::value_t divisor_q;
	egcd_pkg::value_t coef_x_q;
	egcd_pkg::value_t coef_y_q;

	egcd_pkg::div_res_t div_res;
	egcd_pkg::value_t   red_x;
	egcd_pkg::value_t   red_y;
	logic               req_fire;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;

	// Shared unit: divides r0 by r1 and forms q*s1 and q*t1.
	egcd_div_unit u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LAUNCH),
		.num    (r0_q),
		.den    (r1_q),
		.s1     (s1_q),
		.t1     (t1_q),
		.res    (div_res)
	);

	egcd_reduce u_reduce (
		.s0     (s0_q),
		.s1     (s1_q),
		.t0     (t0_q),
		.t1     (t1_q),
		.coef_x (red_x),
		.coef_y (red_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r0_q        <= '0;
			r1_q        <= '0;
			s0_q        <= '0;
			s1_q        <= '0;
			t0_q        <= '0;
			t1_q        <= '0;
			zero_a_q    <= 1'b0;
			zero_b_q    <= 1'b0;
			res_valid_q <= 1'b0;
			divisor_q   <= '0;
			coef_x_q    <= '0;
			coef_y_q    <= '0;
		end else begin
			// output register: load from the final state, else drain on acceptance
			if (state_q == ST_FIN && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						r0_q     <= a_value;
						r1_q     <= b_value;
						s0_q     <= egcd_pkg::COEF_W'(1);
						s1_q     <= '0;
						t0_q     <= '0;
						t1_q     <= egcd_pkg::COEF_W'(1);
						zero_a_q <= (a_value == '0);
						zero_b_q <= (b_value == '0);
						if (a_value == '0 || b_value == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_res.done) begin
						r0_q <= r1_q;
						r1_q <= div_res.rem;
						s0_q <= s1_q;
						s1_q <= s0_q - div_res.prod_s;
						t0_q <= t1_q;
						t1_q <= t0_q - div_res.prod_t;
						if (div_res.rem == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_FIN: begin
					// load only when the output register is free or draining
					if (!res_valid_q || res_ready) begin
						state_q <= ST_IDLE;
						if (zero_b_q) begin
							divisor_q <= r0_q;
							coef_x_q  <= '0;
							coef_y_q  <= '0;
						end else if (zero_a_q) begin
							divisor_q <= r1_q;
							coef_x_q  <= '0;
							coef_y_q  <= egcd_pkg::VALUE_BITS'(1);
						end else begin
							divisor_q <= r0_q;
							coef_x_q  <= red_x;
							coef_y_q  <= red_y;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign divisor   = divisor_q;
	assign coef_x    = coef_x_q;
	assign coef_y    = coef_y_q;

	// A taken request always makes the block busy on the next cycle.
	`EGCD_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_fire, !req_ready)
	// The loop only finishes once the remainder has reached zero.
	`EGCD_ASSERT_IMP(a_fin_rem_zero, clk, arst_n, (state_q == ST_FIN) && !zero_a_q && !zero_b_q, r1_q == '0)
	// The divider reports completion only while the sequencer waits for it.
	`EGCD_ASSERT_IMP(a_done_in_wait, clk, arst_n, div_res.done, state_q == ST_WAIT)

endmodule

@@ rtl/egcd_div_unit.sv @@
// Shared restoring divider, one quotient bit per cycle, that also forms
// q*s1 and q*t1 by shift-and-add. Depends on egcd_pkg.
module egcd_div_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  egcd_pkg::value_t  num,
	input  egcd_pkg::value_t  den,
	input  egcd_pkg::coef_t   s1,
	input  egcd_pkg::coef_t   t1,
	output egcd_pkg::div_res_t res
);

	logic                      busy_q;
	logic                      done_q;
	logic [egcd_pkg::CNT_W-1:0] cnt_q;
	egcd_pkg::value_t          rem_q;
	egcd_pkg::value_t          num_q;
	egcd_pkg::coef_t           ps_q;
	egcd_pkg::coef_t           pt_q;

	logic [egcd_pkg::VALUE_BITS:0] trial;
	logic [egcd_pkg::VALUE_BITS:0] diff;
	logic                          ge;
	egcd_pkg::value_t              rem_next;
	egcd_pkg::coef_t               ps_next;
	egcd_pkg::coef_t               pt_next;

	always_comb begin
		trial    = {rem_q, num_q[egcd_pkg::VALUE_BITS-1]};
		diff     = trial - {1'b0, den};
		ge       = (trial >= {1'b0, den});
		// remainder stays below den, so it fits back in VALUE_BITS
		rem_next = ge ? diff[egcd_pkg::VALUE_BITS-1:0] : trial[egcd_pkg::VALUE_BITS-1:0];
		ps_next  = {ps_q[egcd_pkg::COEF_W-2:0], 1'b0} + (ge ? s1 : '0);
		pt_next  = {pt_q[egcd_pkg::COEF_W-2:0], 1'b0} + (ge ? t1 : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			num_q  <= '0;
			ps_q   <= '0;
			pt_q   <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= egcd_pkg::CNT_W'(egcd_pkg::VALUE_BITS - 1);
				rem_q  <= '0;
				num_q  <= num;
				ps_q   <= '0;
				pt_q   <= '0;
			end else if (busy_q) begin
				rem_q <= rem_next;
				num_q <= {num_q[egcd_pkg::VALUE_BITS-2:0], 1'b0};
				ps_q  <= ps_next;
				pt_q  <= pt_next;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else begin
				// done is a single-cycle pulse
				done_q <= 1'b0;
			end
		end
	end

	assign res.done   = done_q;
	assign res.rem    = rem_q;
	assign res.prod_s = ps_q;
	assign res.prod_t = pt_q;

endmodule

@@ rtl/egcd_reduce.sv @@
// Final reduction of the Bezout coefficients into the least nonnegative
// solution of b*y - a*x = g. Depends on egcd_pkg.
module egcd_reduce (
	input  egcd_pkg::coef_t  s0,
	input  egcd_pkg::coef_t  s1,
	input  egcd_pkg::coef_t  t0,
	input  egcd_pkg::coef_t  t1,
	output egcd_pkg::value_t coef_x,
	output egcd_pkg::value_t coef_y
);

	egcd_pkg::coef_t m;
	egcd_pkg::coef_t n;
	egcd_pkg::coef_t v;
	egcd_pkg::coef_t xs;
	egcd_pkg::coef_t ys;

	// After the last step |s1| = b/g and |t1| = a/g, while |s0| <= b/g and
	// |t0| <= a/g, so one conditional add lands each value in range.
	always_comb begin
		m = s1[egcd_pkg::COEF_W-1] ? -s1 : s1;
		n = t1[egcd_pkg::COEF_W-1] ? -t1 : t1;
		v = -s0;
		if (v[egcd_pkg::COEF_W-1]) begin
			xs = v + m;
		end else if (v == m) begin
			xs = '0;
		end else begin
			xs = v;
		end
		if (t0[egcd_pkg::COEF_W-1] || t0 == '0) begin
			ys = t0 + n;
		end else begin
			ys = t0;
		end
		// y lives in [1, a/g]: a zero residue means a/g
		if (ys == '0) begin
			ys = n;
		end
	end

	assign coef_x = xs[egcd_pkg::VALUE_BITS-1:0];
	assign coef_y = ys[egcd_pkg::VALUE_BITS-1:0];

endmodule
